/* rtl/mpq_pkg.sv */
package mpq_pkg;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam int PRI_W  = 8;
    localparam int ID_W   = 8;
    localparam int OCC_W  = 5;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 3;

    typedef struct packed {
        logic             valid;
        logic [PRI_W-1:0] pri;
        logic [ID_W-1:0]  id;
    } t_slot;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [PRI_W-1:0] pri;
        logic [ID_W-1:0]  id;
    } t_cmd;

endpackage

/* rtl/min_priority_queue.sv */
// A result is registered and shown on the master side in the cycle after it is accepted.
// Throughput: one insert or remove per cycle unless stalled; one compare-and-shift per cell.
// Back-pressure: the output register frees the slave side whenever it is empty or being taken.
// Reset (synchronous, active low): all cells empty and zeroed, count zero, no result pending.
module min_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // job_id[7:0], job_priority[15:8]
    input  logic [mpq_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_id[7:0], out_priority[15:8], occupancy[20:16], zero[23:21]
    output logic [mpq_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // out_valid[0], refused_full[1], was_empty[2]
    output logic [mpq_pkg::M_USER_W-1:0]  m_axis_tuser
);

    localparam int CW = $clog2(DEPTH + 1);

    mpq_pkg::t_cmd  w_cmd;
    mpq_pkg::t_slot w_slot [DEPTH];
    logic           w_keep [DEPTH];
    logic           w_accept;
    logic           w_full;
    logic           w_empty;

    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_m_valid;
    logic [mpq_pkg::M_DATA_W-1:0]  r_m_data;
    logic [mpq_pkg::M_USER_W-1:0]  r_m_user;
    logic [mpq_pkg::M_DATA_W-1:0]  n_m_data;
    logic [mpq_pkg::M_USER_W-1:0]  n_m_user;
    logic [CW+4:0]                 w_count_ext;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = w_slot[DEPTH-1].valid;
    assign w_empty       = !w_slot[0].valid;

    assign w_cmd.ins = w_accept && (s_axis_tuser == mpq_pkg::FUNC_INSERT) && !w_full;
    assign w_cmd.rem = w_accept && (s_axis_tuser == mpq_pkg::FUNC_REMOVE) && !w_empty;
    assign w_cmd.id  = s_axis_tdata[7:0];
    assign w_cmd.pri = s_axis_tdata[15:8];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        mpq_pkg::t_slot w_left;
        mpq_pkg::t_slot w_right;
        logic           w_lkeep;
        if (g == 0) begin : g_head
            assign w_left  = '0;
            assign w_lkeep = 1'b1;
        end else begin : g_mid
            assign w_left  = w_slot[g-1];
            assign w_lkeep = w_keep[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_slot[g+1];
        end
        mpq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_left_slot  (w_left),
            .i_left_keep  (w_lkeep),
            .i_right_slot (w_right),
            .o_slot       (w_slot[g]),
            .o_keep       (w_keep[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.rem) begin
            n_count = r_count - CW'(1);
        end
        w_count_ext = {5'b0, n_count};
        n_m_user[0] = w_cmd.rem;
        n_m_user[1] = w_accept && (s_axis_tuser == mpq_pkg::FUNC_INSERT) && w_full;
        n_m_user[2] = w_accept && (s_axis_tuser == mpq_pkg::FUNC_REMOVE) && w_empty;
        n_m_data    = '0;
        if (w_cmd.rem) begin
            n_m_data[7:0]  = w_slot[0].id;
            n_m_data[15:8] = w_slot[0].pri;
        end
        n_m_data[20:16] = w_count_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= n_m_data;
            r_m_user <= n_m_user;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

/* rtl/mpq_cell.sv */
module mpq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mpq_pkg::t_cmd  i_cmd,
    input  mpq_pkg::t_slot i_left_slot,
    input  logic           i_left_keep,
    input  mpq_pkg::t_slot i_right_slot,
    output mpq_pkg::t_slot o_slot,
    output logic           o_keep
);

    mpq_pkg::t_slot r_slot;
    mpq_pkg::t_slot n_slot;
    mpq_pkg::t_slot w_new;

    assign o_slot = r_slot;
    assign o_keep = r_slot.valid && (r_slot.pri <= i_cmd.pri);

    always_comb begin
        w_new.valid = 1'b1;
        w_new.pri   = i_cmd.pri;
        w_new.id    = i_cmd.id;
        n_slot      = r_slot;
        if (i_cmd.ins) begin
            if (o_keep) begin
                n_slot = r_slot;
            end else if (i_left_keep) begin
                n_slot = w_new;
            end else begin
                n_slot = i_left_slot;
            end
        end else if (i_cmd.rem) begin
            n_slot = i_right_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule

/* rtl/mpq_check.sv */
module mpq_check #(
    parameter int DEPTH = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [mpq_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic [mpq_pkg::M_USER_W-1:0] m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tuser))
        else $error("more than one status flag set");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata[20:0] == 21'd0)
        else $error("empty remove returned data or nonzero occupancy");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[20:16] == 5'(DEPTH)
            && m_axis_tdata[15:0] == 16'd0)
        else $error("refused insert with queue not full");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with no pending result");

endmodule

bind min_priority_queue mpq_check #(.DEPTH(DEPTH)) u_mpq_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* verif/mpq_tb_pkg.sv */
package mpq_tb_pkg;

    localparam int QUEUE_DEPTH = 16;

    typedef struct packed {
        logic                      got_job;
        logic [mpq_pkg::ID_W-1:0]  job_id;
        logic [mpq_pkg::PRI_W-1:0] job_pri;
        logic                      refused_full;
        logic                      was_empty;
        logic [mpq_pkg::OCC_W-1:0] occupancy;
    } t_job_result;

    class job_queue_scoreboard;

        logic [mpq_pkg::PRI_W-1:0] slot_pri [QUEUE_DEPTH];
        logic [mpq_pkg::ID_W-1:0]  slot_id  [QUEUE_DEPTH];
        int unsigned               jobs_held;
        t_job_result               expected_q [$];
        int unsigned               mismatches;

        function new();
            foreach (slot_pri[k]) begin
                slot_pri[k] = '0;
                slot_id[k]  = '0;
            end
            jobs_held  = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_transaction(logic func, logic [mpq_pkg::ID_W-1:0] id,
                                       logic [mpq_pkg::PRI_W-1:0] pri);
            t_job_result res;
            int unsigned pos;
            res = '0;
            if (func == mpq_pkg::FUNC_INSERT) begin
                if (jobs_held >= QUEUE_DEPTH) begin
                    res.refused_full = 1'b1;
                end else begin
                    // equal priorities stay behind earlier arrivals
                    pos = jobs_held;
                    while (pos > 0 && slot_pri[pos-1] > pri) begin
                        slot_pri[pos] = slot_pri[pos-1];
                        slot_id[pos]  = slot_id[pos-1];
                        pos--;
                    end
                    slot_pri[pos] = pri;
                    slot_id[pos]  = id;
                    jobs_held++;
                end
            end else begin
                if (jobs_held == 0) begin
                    res.was_empty = 1'b1;
                end else begin
                    res.got_job = 1'b1;
                    res.job_id  = slot_id[0];
                    res.job_pri = slot_pri[0];
                    for (int k = 1; k < jobs_held; k++) begin
                        slot_pri[k-1] = slot_pri[k];
                        slot_id[k-1]  = slot_id[k];
                    end
                    jobs_held--;
                    slot_pri[jobs_held] = '0;
                    slot_id[jobs_held]  = '0;
                end
            end
            res.occupancy = jobs_held[mpq_pkg::OCC_W-1:0];
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [mpq_pkg::M_DATA_W-1:0] tdata,
                                   logic [mpq_pkg::M_USER_W-1:0] tuser);
            t_job_result exp_res;
            t_job_result act;
            act.got_job      = tuser[0];
            act.refused_full = tuser[1];
            act.was_empty    = tuser[2];
            act.job_id       = tdata[7:0];
            act.job_pri      = tdata[15:8];
            act.occupancy    = tdata[20:16];
            if (expected_q.size() == 0) begin
                $error("unexpected result: tdata %h tuser %b", tdata, tuser);
                mismatches++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (act.got_job !== exp_res.got_job) begin
                $error("out_valid: expected %0d, got %0d", exp_res.got_job, act.got_job);
                mismatches++;
            end
            if (act.job_id !== exp_res.job_id) begin
                $error("out_id: expected %0d, got %0d", exp_res.job_id, act.job_id);
                mismatches++;
            end
            if (act.job_pri !== exp_res.job_pri) begin
                $error("out_priority: expected %0d, got %0d", exp_res.job_pri, act.job_pri);
                mismatches++;
            end
            if (act.refused_full !== exp_res.refused_full) begin
                $error("refused_full: expected %0d, got %0d",
                       exp_res.refused_full, act.refused_full);
                mismatches++;
            end
            if (act.was_empty !== exp_res.was_empty) begin
                $error("was_empty: expected %0d, got %0d", exp_res.was_empty, act.was_empty);
                mismatches++;
            end
            if (act.occupancy !== exp_res.occupancy) begin
                $error("occupancy: expected %0d, got %0d", exp_res.occupancy, act.occupancy);
                mismatches++;
            end
        endfunction

    endclass

endpackage

/* verif/tb_top.sv */
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mpq_pkg::ID_W-1:0] DIR_ID [mpq_tb_pkg::QUEUE_DEPTH] = '{
        8'd0, 8'd255, 8'd17, 8'd18, 8'd30, 8'd31, 8'd32, 8'd40,
        8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48
    };
    localparam logic [mpq_pkg::PRI_W-1:0] DIR_PRI [mpq_tb_pkg::QUEUE_DEPTH] = '{
        8'd255, 8'd1, 8'd0, 8'd128, 8'd5, 8'd5, 8'd5, 8'd127,
        8'd254, 8'd5, 8'd1, 8'd255, 8'd64, 8'd2, 8'd3, 8'd200
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // job_id[7:0], job_priority[15:8]
    logic [mpq_pkg::S_DATA_W-1:0]  s_axis_tdata;
    logic                          s_axis_tuser;   // func[0]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // out_id[7:0], out_priority[15:8], occupancy[20:16]
    logic [mpq_pkg::M_DATA_W-1:0]  m_axis_tdata;
    // out_valid[0], refused_full[1], was_empty[2]
    logic [mpq_pkg::M_USER_W-1:0]  m_axis_tuser;

    int unsigned          send_idle_pct = 20;
    int unsigned          recv_idle_pct = 85;

    mpq_tb_pkg::job_queue_scoreboard sb = new();

    min_priority_queue #(
        .DEPTH(mpq_tb_pkg::QUEUE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(input logic func, input logic [mpq_pkg::ID_W-1:0] id,
                             input logic [mpq_pkg::PRI_W-1:0] pri);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pri, id};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_transaction(func, id, pri);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_directed();
        send_item(mpq_pkg::FUNC_REMOVE, 8'd255, 8'd255);
        for (int k = 0; k < mpq_tb_pkg::QUEUE_DEPTH; k++) begin
            send_item(mpq_pkg::FUNC_INSERT, DIR_ID[k], DIR_PRI[k]);
        end
        send_item(mpq_pkg::FUNC_INSERT, 8'd99, 8'd10);
        repeat (4) send_item(mpq_pkg::FUNC_REMOVE, 8'd0, 8'd0);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned                left;
        int unsigned                run_len;
        int unsigned                ins_pct;
        int unsigned                pick;
        logic                       func;
        logic [mpq_pkg::PRI_W-1:0]  pri;
        logic [mpq_pkg::ID_W-1:0]   id;
        left = count;
        while (left > 0) begin
            run_len = $urandom_range(15, 60);
            if (run_len > left) run_len = left;
            case ($urandom_range(0, 2))
                0: ins_pct = 80;
                1: ins_pct = 50;
                default: ins_pct = 25;
            endcase
            repeat (run_len) begin
                func = ($urandom_range(0, 99) < ins_pct) ? mpq_pkg::FUNC_INSERT
                                                         : mpq_pkg::FUNC_REMOVE;
                pick = $urandom_range(0, 99);
                // mostly a narrow range so that ties are common
                if (pick < 65)      pri = 8'($urandom_range(1, 6));
                else if (pick < 95) pri = 8'($urandom_range(1, 255));
                else if (pick < 98) pri = 8'd255;
                else                pri = 8'd0;
                id = 8'($urandom_range(0, 255));
                send_item(func, id, pri);
            end
            left -= run_len;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mpq_pkg::FUNC_INSERT;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 20;
        recv_idle_pct = 85;
        run_directed();
        run_random(180);
        wait_drained();

        send_idle_pct = 85;
        recv_idle_pct = 20;
        run_random(200);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(200);
        wait_drained();
        repeat (4) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
